// File: sv/dvd_pkg.sv
`timescale 1ns / 1ps

package dvd_pkg;

    // Set geometry; SET_CAPACITY must be a power of two
    localparam int SET_CAPACITY = 4096;
    localparam int SLOT_W       = $clog2(SET_CAPACITY);
    localparam int COORD_BITS   = 32;
    localparam int NUM_COORDS   = 3;
    localparam int STEP_W       = $clog2(NUM_COORDS);
    localparam int VNUM_W       = 20;

    // Mesh generation mark kept with each slot
    localparam int EPOCH_W      = 8;

    // Hash: only bits up to SLOT_W + HASH_SHIFT of the 64-bit product sum matter
    localparam int HASH_SHIFT   = 29;
    localparam int HASH_W       = SLOT_W + HASH_SHIFT;
    localparam int MUL_LO_W     = 32;
    localparam int MUL_HI_W     = HASH_W - MUL_LO_W;

    localparam logic [63:0] HASH_MUL_X = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] HASH_MUL_Y = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] HASH_MUL_Z = 64'h1656_67B1_9E37_79F9;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [EPOCH_W-1:0]    epoch_t;
    typedef logic [STEP_W-1:0]     step_t;

    localparam step_t STEP_LAST = STEP_W'(NUM_COORDS - 1);

    typedef struct packed {
        epoch_t epoch;
        coord_t z;
        coord_t y;
        coord_t x;
    } dvd_entry_t;

    typedef struct packed {
        logic  done;
        slot_t slot;
    } dvd_hash_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } dvd_state_t;

endpackage

// File: sv/dvd_hash.sv
`timescale 1ns / 1ps

module dvd_hash (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  dvd_pkg::coord_t           key_x,
    input  dvd_pkg::coord_t           key_y,
    input  dvd_pkg::coord_t           key_z,
    output dvd_pkg::dvd_hash_status_t status
);
    import dvd_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    step_t                   step_reg, step_next;
    logic [HASH_W-1:0]       acc_reg, acc_next;

    coord_t                  key;
    logic [63:0]             mul_c;
    logic [2*MUL_LO_W-1:0]   prod_lo;
    logic [MUL_HI_W-1:0]     prod_hi;
    logic [HASH_W-1:0]       term;

    // Operand select: one coordinate per cycle
    always_comb begin
        case (step_reg)
            2'd0: begin
                key   = key_x;
                mul_c = HASH_MUL_X;
            end
            2'd1: begin
                key   = key_y;
                mul_c = HASH_MUL_Y;
            end
            2'd2: begin
                key   = key_z;
                mul_c = HASH_MUL_Z;
            end
            default: begin
                key   = '0;
                mul_c = '0;
            end
        endcase
    end

    // Shared multiplier: low 32 bits of constant in full, upper bits only as far as needed
    assign prod_lo = key * mul_c[MUL_LO_W-1:0];
    assign prod_hi = key[MUL_HI_W-1:0] * mul_c[HASH_W-1:MUL_LO_W];
    assign term    = prod_lo[HASH_W-1:0] + {prod_hi, {MUL_LO_W{1'b0}}};

    // Step sequencer and xor accumulator
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next  = acc_reg ^ term;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Fold: h ^ (h >> 29), low slot bits
    assign status.done = done_reg;
    assign status.slot = acc_reg[SLOT_W-1:0] ^ acc_reg[HASH_SHIFT +: SLOT_W];

endmodule

// File: sv/duplicate_vertex_detector_core.sv
`timescale 1ns / 1ps

// Duplicate vertex detector. Each input beat carries one quantized vertex
// (x, y, z as signed 32-bit fixed point) and a first-of-mesh flag; each
// output beat returns the vertex number within the mesh, a duplicate flag
// and a set-full flag. Triples live in a 4096-slot open-addressed hash table
// with linear probing in a single-port memory. Each item passes through
// these steps: accept, the hash unit (one pass through the shared multiplier
// per coordinate, then the fold and the slot read), probing one slot per
// cycle until an empty slot, a match or a full table settles it, and the
// load of the output register once it is free; s_ready stays low until
// then. A mesh start bumps an 8-bit generation mark instead of clearing the
// table; after reset, and on every 255th mesh start, a clearing pass over
// all 4096 slots runs first, with s_ready low. The output register lets the
// next vertex be accepted while a result waits.
module duplicate_vertex_detector_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [dvd_pkg::COORD_BITS-1:0] s_pos_x,
    input  logic signed [dvd_pkg::COORD_BITS-1:0] s_pos_y,
    input  logic signed [dvd_pkg::COORD_BITS-1:0] s_pos_z,
    input  logic                                s_first_of_mesh,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dvd_pkg::VNUM_W-1:0]          m_vertex_number,
    output logic                                m_is_duplicate,
    output logic                                m_set_full
);
    import dvd_pkg::*;

    dvd_state_t          state_reg, state_next;
    slot_t               clr_addr_reg, clr_addr_next;
    epoch_t              epoch_reg, epoch_next;
    logic                item_active_reg, item_active_next;
    logic [VNUM_W-1:0]   vcount_reg, vcount_next;
    logic                m_valid_reg, m_valid_next;

    coord_t              key_x_reg, key_x_next;
    coord_t              key_y_reg, key_y_next;
    coord_t              key_z_reg, key_z_next;
    slot_t               slot_reg, slot_next;
    slot_t               probes_reg, probes_next;
    logic                dup_reg, dup_next;
    logic                full_reg, full_next;
    logic [VNUM_W-1:0]   m_vnum_reg, m_vnum_next;
    logic                m_dup_reg, m_dup_next;
    logic                m_full_reg, m_full_next;

    dvd_entry_t          mem [SET_CAPACITY];
    dvd_entry_t          rd_data_reg;
    dvd_entry_t          mem_wdata;
    slot_t               mem_addr;
    logic                mem_we;
    logic                mem_re;

    logic                hash_start;
    dvd_hash_status_t    hash_status;

    logic                in_beat;
    logic                out_free;
    logic                entry_used;
    logic                key_match;

    dvd_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key_x   (key_x_reg),
        .key_y   (key_y_reg),
        .key_z   (key_z_reg),
        .status  (hash_status)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Slot is live only if written in the current mesh generation
    assign entry_used = (rd_data_reg.epoch == epoch_reg);
    assign key_match  = (rd_data_reg.x == key_x_reg) && (rd_data_reg.y == key_y_reg) &&
                        (rd_data_reg.z == key_z_reg);

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        epoch_next       = epoch_reg;
        item_active_next = item_active_reg;
        vcount_next      = vcount_reg;
        m_valid_next     = m_valid_reg;
        key_x_next       = key_x_reg;
        key_y_next       = key_y_reg;
        key_z_next       = key_z_reg;
        slot_next        = slot_reg;
        probes_next      = probes_reg;
        dup_next         = dup_reg;
        full_next        = full_reg;
        m_vnum_next      = m_vnum_reg;
        m_dup_next       = m_dup_reg;
        m_full_next      = m_full_reg;
        hash_start       = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = slot_reg;
        mem_wdata        = '{epoch: epoch_reg, z: key_z_reg, y: key_y_reg, x: key_x_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    key_x_next       = s_pos_x;
                    key_y_next       = s_pos_y;
                    key_z_next       = s_pos_z;
                    item_active_next = 1'b1;
                    if (s_first_of_mesh) begin
                        vcount_next = '0;
                        if (epoch_reg == '1) begin
                            // generation mark exhausted: sweep the table
                            epoch_next    = EPOCH_W'(1);
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + 1'b1;
                            hash_start = 1'b1;
                            state_next = ST_HASH;
                        end
                    end else begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    if (item_active_reg) begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HASH: begin
                if (hash_status.done) begin
                    slot_next   = hash_status.slot;
                    probes_next = '0;
                    mem_re      = 1'b1;
                    mem_addr    = hash_status.slot;
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!entry_used) begin
                    // empty slot: insert
                    mem_we     = 1'b1;
                    dup_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_DONE;
                end else if (key_match) begin
                    dup_next   = 1'b1;
                    full_next  = 1'b0;
                    state_next = ST_DONE;
                end else if (probes_reg == '1) begin
                    // every slot visited, no room
                    dup_next   = 1'b0;
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    slot_next   = slot_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    mem_re      = 1'b1;
                    mem_addr    = slot_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_vnum_next      = vcount_reg;
                    m_dup_next       = dup_reg;
                    m_full_next      = full_reg;
                    vcount_next      = vcount_reg + 1'b1;
                    item_active_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            epoch_reg       <= EPOCH_W'(1);
            item_active_reg <= 1'b0;
            vcount_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            epoch_reg       <= epoch_next;
            item_active_reg <= item_active_next;
            vcount_reg      <= vcount_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_x_reg  <= key_x_next;
        key_y_reg  <= key_y_next;
        key_z_reg  <= key_z_next;
        slot_reg   <= slot_next;
        probes_reg <= probes_next;
        dup_reg    <= dup_next;
        full_reg   <= full_next;
        m_vnum_reg <= m_vnum_next;
        m_dup_reg  <= m_dup_next;
        m_full_reg <= m_full_next;
    end

    // Single-port slot memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_vertex_number = m_vnum_reg;
    assign m_is_duplicate  = m_dup_reg;
    assign m_set_full      = m_full_reg;

endmodule
